@@ sv/assert_macros.svh @@
// Assertion macros shared by the cluster core RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/clc_pkg.sv @@
// Package for the competitive learning cluster core: types, codes, constants.
// No dependencies; used by clc_ctrl, clc_datapath and the top level.
package clc_pkg;

    localparam int FEAT_W      = 4;
    localparam int MAX_DIM     = 16;
    localparam int IDX_W       = 3;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 56;

    localparam logic [15:0] ALPHA_INIT_RST   = 16'd32768;
    localparam logic [15:0] DECAY_RATE_RST   = 16'd62915;
    localparam logic [15:0] MIN_ALPHA_RST    = 16'd655;
    localparam logic [7:0]  EPOCH_LENGTH_RST = 8'd4;

    localparam logic [32:0] DIST_MAX   = 33'h1_FFFF_FFFF;
    localparam logic [15:0] ONE_Q15    = 16'h8000;
    localparam logic [1:0]  DRAIN_LAST = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ALPHA_INIT   = 2'd0;
    localparam logic [1:0] REG_DECAY_RATE   = 2'd1;
    localparam logic [1:0] REG_MIN_ALPHA    = 2'd2;
    localparam logic [1:0] REG_EPOCH_LENGTH = 2'd3;

    typedef enum logic [1:0] {
        MODE_TRAIN    = 2'd0,
        MODE_CLASSIFY = 2'd1,
        MODE_LOAD     = 2'd2,
        MODE_RESTART  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE,
        ST_APPLY,
        ST_RESULT
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [3:0]  feature_bits;
        logic [2:0]  cluster_index;
        logic [3:0]  dim_index;
        logic [15:0] weight_value;
    } in_item_t;

    typedef struct packed {
        logic             load_in;
        logic             scan_vld;
        logic [IDX_W-1:0] scan_idx;
        logic             do_update;
        logic             do_load;
        logic             do_restart;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  active;
    } sts_t;

    typedef struct packed {
        logic [15:0] epochs_done;
        logic        learning_done;
        logic        weights_updated;
        logic [32:0] winner_distance;
        logic [2:0]  winner;
    } result_t;

    // Power-up weights: two starting clusters, everything else zero.
    function automatic logic [15:0] init_weight(input int c, input int j);
        logic [15:0] w;
        w = 16'd0;
        if (c == 0) begin
            case (j)
                0:       w = 16'd6553;
                1:       w = 16'd19660;
                2:       w = 16'd16384;
                3:       w = 16'd29491;
                default: w = 16'd0;
            endcase
        end else if (c == 1) begin
            case (j)
                0:       w = 16'd26214;
                1:       w = 16'd13107;
                2:       w = 16'd22937;
                3:       w = 16'd9830;
                default: w = 16'd0;
            endcase
        end
        return w;
    endfunction

    // Feature j of the item; positions past the input width read as zero.
    function automatic logic feature_at(input logic [FEAT_W-1:0] bits, input logic [3:0] j);
        logic [MAX_DIM-1:0] ext;
        ext = {{(MAX_DIM-FEAT_W){1'b0}}, bits};
        return ext[j];
    endfunction

endpackage

@@ sv/clc_ctrl.sv @@
// Controller state machine for the cluster core: sequences scan, update, apply.
// Depends on clc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clc_ctrl #(
    parameter int CLUSTERS = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  clc_pkg::mode_t    in_mode,
    input  logic              out_free,
    input  clc_pkg::sts_t     sts,
    output logic              s_tready,
    output logic              out_load,
    output clc_pkg::cmd_t     cmd
);

    localparam int CIDX_W = $clog2(CLUSTERS);
    localparam int IW     = clc_pkg::IDX_W;
    localparam logic [CIDX_W-1:0] LAST_IDX = CIDX_W'(CLUSTERS - 1);

    clc_pkg::state_t   state_reg, state_next;
    logic [CIDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [1:0]        drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg    <= clc_pkg::ST_IDLE;
            scan_idx_reg <= '0;
            drain_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            drain_reg    <= drain_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        drain_next     = drain_reg;
        s_tready       = 1'b0;
        out_load       = 1'b0;
        cmd            = '0;
        cmd.scan_idx   = IW'(scan_idx_reg);
        case (state_reg)
            clc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in   = 1'b1;
                    scan_idx_next = '0;
                    if (in_mode == clc_pkg::MODE_TRAIN || in_mode == clc_pkg::MODE_CLASSIFY) begin
                        state_next = clc_pkg::ST_SCAN;
                    end else begin
                        state_next = clc_pkg::ST_APPLY;
                    end
                end
            end
            clc_pkg::ST_SCAN: begin
                cmd.scan_vld = 1'b1;
                if (scan_idx_reg == LAST_IDX) begin
                    drain_next = '0;
                    state_next = clc_pkg::ST_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            clc_pkg::ST_DRAIN: begin
                // wait for the last distance to reach the winner register
                if (drain_reg == clc_pkg::DRAIN_LAST) begin
                    if (sts.mode == clc_pkg::MODE_TRAIN && sts.active) begin
                        state_next = clc_pkg::ST_UPDATE;
                    end else begin
                        state_next = clc_pkg::ST_RESULT;
                    end
                end else begin
                    drain_next = drain_reg + 1'b1;
                end
            end
            clc_pkg::ST_UPDATE: begin
                cmd.do_update = 1'b1;
                state_next    = clc_pkg::ST_RESULT;
            end
            clc_pkg::ST_APPLY: begin
                cmd.do_load    = (sts.mode == clc_pkg::MODE_LOAD);
                cmd.do_restart = (sts.mode == clc_pkg::MODE_RESTART);
                state_next     = clc_pkg::ST_RESULT;
            end
            clc_pkg::ST_RESULT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = clc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = clc_pkg::ST_IDLE;
            end
        endcase
    end

    `CLC_ASSERT_IMP(a_update_only_when_training, (state_reg == clc_pkg::ST_UPDATE), (sts.mode == clc_pkg::MODE_TRAIN && sts.active), "weight update outside an active training item")
    `CLC_ASSERT_IMP(a_scan_index_in_range, (state_reg == clc_pkg::ST_SCAN), (scan_idx_reg <= LAST_IDX), "scan index past last cluster")
    `CLC_ASSERT_NXT(a_result_held_until_room, (state_reg == clc_pkg::ST_RESULT && !out_free), (state_reg == clc_pkg::ST_RESULT), "result dropped while output stage full")

endmodule

@@ sv/clc_datapath.sv @@
// Datapath for the cluster core: weight rows, distance pipeline, update, rate.
// Depends on clc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clc_datapath #(
    parameter int CLUSTERS = 2,
    parameter int DIM      = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [15:0]         cfg_data,
    input  clc_pkg::in_item_t   in_item,
    input  clc_pkg::cmd_t       cmd,
    output clc_pkg::sts_t       sts,
    output clc_pkg::result_t    result
);

    localparam int CIDX_W = $clog2(CLUSTERS);
    localparam int DIDX_W = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int SUM_W  = 32 + ((DIM > 1) ? $clog2(DIM) : 0);
    localparam int GROUPS = (DIM + 3) / 4;
    localparam int LANES  = GROUPS * 4;
    localparam int SAT_W  = (SUM_W > 33) ? SUM_W : 33;

    // configuration
    logic [15:0] alpha_init_reg, decay_rate_reg, min_alpha_reg;
    logic [7:0]  epoch_length_reg;

    // learning state
    logic [15:0] learning_rate_reg, learning_rate_next;
    logic [7:0]  epoch_item_count_reg, epoch_item_count_next;
    logic [15:0] epoch_count_reg, epoch_count_next;
    logic [15:0] weight_reg  [CLUSTERS][DIM];
    logic [15:0] weight_next [CLUSTERS][DIM];

    // latched item
    clc_pkg::mode_t mode_reg;
    logic [3:0]     feat_reg;
    logic [2:0]     ci_reg;
    logic [3:0]     di_reg;
    logic [15:0]    wv_reg;

    // distance pipeline
    logic [CIDX_W-1:0] rd_idx;
    logic [15:0]       rd_row [DIM];
    logic [31:0]       sq_next [LANES];
    logic [31:0]       sq_reg  [LANES];
    logic [SUM_W-1:0]  part_next [GROUPS];
    logic [SUM_W-1:0]  part_reg  [GROUPS];
    logic [SUM_W-1:0]  sum_next, sum_reg;
    logic              s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [CIDX_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [SUM_W-1:0]  best_dist_reg;
    logic [CIDX_W-1:0] best_idx_reg;

    // update
    logic [15:0] upd_w   [DIM];
    logic [DIM-1:0] lane_chg;
    logic        updated_reg;
    logic [31:0] decay_prod;
    logic [8:0]  epoch_len_eff;
    logic        load_ok;
    logic        scan_mode;
    logic [SAT_W-1:0] best_ext;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            alpha_init_reg   <= clc_pkg::ALPHA_INIT_RST;
            decay_rate_reg   <= clc_pkg::DECAY_RATE_RST;
            min_alpha_reg    <= clc_pkg::MIN_ALPHA_RST;
            epoch_length_reg <= clc_pkg::EPOCH_LENGTH_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                clc_pkg::REG_ALPHA_INIT:   alpha_init_reg   <= cfg_data;
                clc_pkg::REG_DECAY_RATE:   decay_rate_reg   <= cfg_data;
                clc_pkg::REG_MIN_ALPHA:    min_alpha_reg    <= cfg_data;
                clc_pkg::REG_EPOCH_LENGTH: epoch_length_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_in) begin
            mode_reg <= in_item.mode;
            feat_reg <= in_item.feature_bits;
            ci_reg   <= in_item.cluster_index;
            di_reg   <= in_item.dim_index;
            wv_reg   <= in_item.weight_value;
        end
    end

    // one row read per cycle: the scanned cluster, or the winner during update
    assign rd_idx = cmd.do_update ? best_idx_reg : cmd.scan_idx[CIDX_W-1:0];
    assign rd_row = weight_reg[rd_idx];

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        if (j < DIM) begin : g_real
            logic        xb;
            logic [15:0] xv;
            logic [15:0] d;
            logic signed [17:0] diff;
            logic signed [16:0] rate_s;
            logic signed [34:0] prod;
            logic [15:0] delta;

            assign xb = clc_pkg::feature_at(feat_reg, 4'(j));
            assign xv = xb ? clc_pkg::ONE_Q15 : 16'd0;
            assign d  = !xb ? rd_row[j] :
                        (rd_row[j] >= clc_pkg::ONE_Q15) ? (rd_row[j] - clc_pkg::ONE_Q15)
                                                        : (clc_pkg::ONE_Q15 - rd_row[j]);
            assign sq_next[j] = {16'd0, d} * {16'd0, d};

            // w + floor(rate * (x - w) / 2^16); the result stays between w and x
            assign diff   = $signed({2'b00, xv}) - $signed({2'b00, rd_row[j]});
            assign rate_s = $signed({1'b0, learning_rate_reg});
            assign prod   = diff * rate_s;
            assign delta  = prod[31:16];
            assign upd_w[j]    = rd_row[j] + delta;
            assign lane_chg[j] = (prod[34:16] != '0);
        end else begin : g_pad
            assign sq_next[j] = 32'd0;
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            part_next[g] = '0;
            for (int k = 0; k < 4; k++) begin
                part_next[g] = part_next[g] + SUM_W'(sq_reg[g*4+k]);
            end
        end
        sum_next = '0;
        for (int g = 0; g < GROUPS; g++) begin
            sum_next = sum_next + part_reg[g];
        end
    end

    always_ff @(posedge clk) begin
        sq_reg   <= sq_next;
        part_reg <= part_next;
        sum_reg  <= sum_next;
        s1_idx_reg <= cmd.scan_idx[CIDX_W-1:0];
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        // strict less-than keeps the lowest index on a tie
        if (s3_vld_reg && (s3_idx_reg == '0 || sum_reg < best_dist_reg)) begin
            best_dist_reg <= sum_reg;
            best_idx_reg  <= s3_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= cmd.scan_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    assign load_ok = (32'(ci_reg) < CLUSTERS) && (32'(di_reg) < DIM);

    always_comb begin
        weight_next = weight_reg;
        if (cmd.do_load && load_ok) begin
            weight_next[ci_reg[CIDX_W-1:0]][di_reg[DIDX_W-1:0]] = wv_reg;
        end
        if (cmd.do_update) begin
            weight_next[best_idx_reg] = upd_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int c = 0; c < CLUSTERS; c++) begin
                for (int j = 0; j < DIM; j++) begin
                    weight_reg[c][j] <= clc_pkg::init_weight(c, j);
                end
            end
        end else begin
            weight_reg <= weight_next;
        end
    end

    assign decay_prod    = {16'd0, learning_rate_reg} * {16'd0, decay_rate_reg};
    assign epoch_len_eff = (epoch_length_reg == 8'd0) ? 9'd1 : {1'b0, epoch_length_reg};

    always_comb begin
        learning_rate_next    = learning_rate_reg;
        epoch_item_count_next = epoch_item_count_reg;
        epoch_count_next      = epoch_count_reg;
        if (cmd.do_restart) begin
            learning_rate_next    = alpha_init_reg;
            epoch_item_count_next = '0;
            epoch_count_next      = '0;
        end else if (cmd.do_update) begin
            // the count reaching the length closes the epoch, even if lowered meanwhile
            if ({1'b0, epoch_item_count_reg} + 9'd1 >= epoch_len_eff) begin
                epoch_item_count_next = '0;
                learning_rate_next    = decay_prod[31:16];
                if (epoch_count_reg != 16'hFFFF) begin
                    epoch_count_next = epoch_count_reg + 16'd1;
                end
            end else begin
                epoch_item_count_next = epoch_item_count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            learning_rate_reg    <= clc_pkg::ALPHA_INIT_RST;
            epoch_item_count_reg <= '0;
            epoch_count_reg      <= '0;
            updated_reg          <= 1'b0;
        end else begin
            learning_rate_reg    <= learning_rate_next;
            epoch_item_count_reg <= epoch_item_count_next;
            epoch_count_reg      <= epoch_count_next;
            if (cmd.load_in) begin
                updated_reg <= 1'b0;
            end else if (cmd.do_update) begin
                updated_reg <= |lane_chg;
            end
        end
    end

    assign sts.mode   = mode_reg;
    assign sts.active = (learning_rate_reg > min_alpha_reg);

    assign scan_mode = (mode_reg == clc_pkg::MODE_TRAIN) || (mode_reg == clc_pkg::MODE_CLASSIFY);
    assign best_ext  = SAT_W'(best_dist_reg);

    always_comb begin
        result                 = '0;
        result.weights_updated = updated_reg;
        result.learning_done   = ~sts.active;
        result.epochs_done     = epoch_count_reg;
        if (scan_mode) begin
            result.winner          = 3'(best_idx_reg);
            result.winner_distance = (best_ext > SAT_W'(clc_pkg::DIST_MAX))
                                     ? clc_pkg::DIST_MAX : best_ext[32:0];
        end
    end

    `CLC_ASSERT_NXT(a_rate_never_grows_on_update, cmd.do_update, (learning_rate_reg <= $past(learning_rate_reg)), "learning rate grew on an update")
    `CLC_ASSERT_NXT(a_epochs_hold_when_idle, (!cmd.do_update && !cmd.do_restart), $stable(epoch_count_reg), "epoch count moved without update or restart")

endmodule

@@ sv/competitive_learning_cluster_core.sv @@
// Top level of the competitive learning cluster core: ports, output stage.
// Depends on clc_pkg, clc_ctrl and clc_datapath.
// Sequence, accepting edge to m_tvalid: train and classify scan one cluster per scan cycle,
// drain the distance pipe and, for an active train item, update the winner; load/restart
// apply instead. Items are taken one at a time; a held result stalls s_tready.
// Reset: rst_n async low; weights return to their power-up values, rate to alpha_init.
module competitive_learning_cluster_core #(
    parameter int CLUSTERS = 2,
    parameter int DIM      = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] feature_bits, [6:4] cluster_index, [10:7] dim_index,
    // [26:11] weight_value, [31:27] zero
    input  logic [31:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] winner, [35:3] winner_distance, [36] weights_updated,
    // [37] learning_done, [53:38] epochs_done, [55:54] zero
    output logic [55:0] m_tdata
);

    clc_pkg::in_item_t in_item;
    clc_pkg::cmd_t     cmd;
    clc_pkg::sts_t     sts;
    clc_pkg::result_t  result;
    logic              out_free;
    logic              out_load;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [55:0]       m_tdata_reg;

    // split the slave payload into the item fields
    assign in_item.mode          = clc_pkg::mode_t'(s_tuser);
    assign in_item.feature_bits  = s_tdata[3:0];
    assign in_item.cluster_index = s_tdata[6:4];
    assign in_item.dim_index     = s_tdata[10:7];
    assign in_item.weight_value  = s_tdata[26:11];

    // the output register frees up in the same cycle its item is taken
    assign out_free = !m_tvalid_reg || m_tready;

    clc_ctrl #(
        .CLUSTERS (CLUSTERS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .in_mode  (in_item.mode),
        .out_free (out_free),
        .sts      (sts),
        .s_tready (s_tready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    clc_datapath #(
        .CLUSTERS (CLUSTERS),
        .DIM      (DIM)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .in_item  (in_item),
        .cmd      (cmd),
        .sts      (sts),
        .result   (result)
    );

    // hold the result until the sink takes it; drop valid once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (out_load) begin
            m_tdata_reg <= {2'b00, result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ tb/competitive_learning_cluster_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for competitive_learning_cluster_core: winner search, weight learning,
// rate decay per epoch, weight loads and restarts, checked against an in-bench predictor.
// Depends on clc_pkg and the core RTL only.
module competitive_learning_cluster_core_tb;

    localparam int CLUSTERS = 2;
    localparam int DIM      = 4;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    competitive_learning_cluster_core #(
        .CLUSTERS(CLUSTERS),
        .DIM     (DIM)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: weight table, rate, epoch counters and registers.
    // ------------------------------------------------------------------
    logic [15:0] weights [CLUSTERS][DIM];
    logic [15:0] lrate;
    logic [7:0]  ep_items;
    logic [15:0] ep_count;
    logic [15:0] r_alpha;
    logic [15:0] r_decay;
    logic [15:0] r_floor;
    logic [7:0]  r_len;

    clc_pkg::in_item_t cluster_cmds [$];         // items waiting for the driver
    clc_pkg::result_t  winner_reports_due [$];   // predicted results, oldest first
    clc_pkg::in_item_t offered;                  // item currently on the input bus

    int  n_errors   = 0;
    int  n_accepted = 0;
    int  s_gap      = 0;
    int  m_gap      = 0;
    logic steady     = 1'b0;            // no idling on either side while set
    logic long_stall = 1'b0;            // receiver holds off for a long stretch

    // Feature j as a Q1.15 level; positions past the input field read as zero.
    function automatic longint feature_level(logic [3:0] bits, int j);
        return (j < clc_pkg::FEAT_W && bits[j]) ? 64'sd32768 : 64'sd0;
    endfunction

    // Advance the predictor by one item and return the result it owes.
    function automatic clc_pkg::result_t classify_and_learn(clc_pkg::in_item_t it);
        clc_pkg::result_t r;
        longint      best;
        longint      d;
        longint      diff;
        longint      w;
        longint      nw;
        int          win;
        int unsigned span;
        r    = '0;
        best = 0;
        win  = 0;
        case (it.mode)
            clc_pkg::MODE_TRAIN, clc_pkg::MODE_CLASSIFY:
            begin
                // Exact distances; strict compare keeps the lowest index on ties.
                for (int c = 0; c < CLUSTERS; c++)
                begin
                    d = 0;
                    for (int j = 0; j < DIM; j++)
                    begin
                        diff = longint'(weights[c][j]) - feature_level(it.feature_bits, j);
                        d += diff * diff;
                    end
                    if (c == 0 || d < best)
                    begin
                        best = d;
                        win  = c;
                    end
                end
                r.winner          = win[2:0];
                r.winner_distance = (best > longint'(clc_pkg::DIST_MAX))
                                    ? clc_pkg::DIST_MAX : best[32:0];
                if (it.mode == clc_pkg::MODE_TRAIN && lrate > r_floor)
                begin
                    // Move the winner toward the vector; >>> floors the signed step.
                    for (int j = 0; j < DIM; j++)
                    begin
                        w  = longint'(weights[win][j]);
                        nw = w + ((longint'(lrate) * (feature_level(it.feature_bits, j) - w))
                                  >>> 16);
                        if (nw < 0)
                            nw = 0;
                        if (nw > 65535)
                            nw = 65535;
                        if (nw != w)
                            r.weights_updated = 1'b1;
                        weights[win][j] = nw[15:0];
                    end
                    span = (r_len == 8'd0) ? 1 : r_len;
                    if (int'(ep_items) + 1 >= span)
                    begin
                        ep_items = '0;
                        lrate    = 16'((32'(lrate) * 32'(r_decay)) >> 16);
                        if (ep_count != 16'hFFFF)
                            ep_count++;
                    end
                    else
                    begin
                        ep_items++;
                    end
                end
            end
            clc_pkg::MODE_LOAD:
            begin
                if (it.cluster_index < CLUSTERS && it.dim_index < DIM)
                    weights[it.cluster_index][it.dim_index] = it.weight_value;
            end
            default:
            begin
                lrate    = r_alpha;
                ep_items = '0;
                ep_count = '0;
            end
        endcase
        r.learning_done = !(lrate > r_floor);
        r.epochs_done   = ep_count;
        return r;
    endfunction

    function automatic int draw_gap();
        // Mostly short gaps, now and then a long one.
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    function automatic clc_pkg::in_item_t make_cmd(clc_pkg::mode_t m, int bits, int ci, int di,
                                                   int wv);
        clc_pkg::in_item_t it;
        it.mode          = m;
        it.feature_bits  = bits[3:0];
        it.cluster_index = ci[2:0];
        it.dim_index     = di[3:0];
        it.weight_value  = wv[15:0];
        return it;
    endfunction

    // Random item: mostly training with random vectors, some classify, loads
    // and restarts. Loads mostly hit the table, some fall outside it.
    function automatic clc_pkg::in_item_t random_cmd();
        clc_pkg::in_item_t it;
        int unsigned       pick;
        it   = clc_pkg::in_item_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.mode = clc_pkg::MODE_TRAIN;
        else if (pick < 78)
            it.mode = clc_pkg::MODE_CLASSIFY;
        else if (pick < 94)
            it.mode = clc_pkg::MODE_LOAD;
        else
            it.mode = clc_pkg::MODE_RESTART;
        if ($urandom_range(0, 3) != 0)
        begin
            it.cluster_index = 3'($urandom_range(0, CLUSTERS - 1));
            it.dim_index     = 4'($urandom_range(0, DIM - 1));
        end
        if ($urandom_range(0, 7) != 0)
            it.weight_value = 16'($urandom_range(0, 32768));
        return it;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: offer the next queued item, predict it when accepted, then
    // hold the bus idle for a random gap before the next one.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_gap    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                winner_reports_due.push_back(classify_and_learn(offered));
                n_accepted++;
            end
            // The bus is free when nothing is offered or the offer was just taken.
            if (!s_tvalid || s_tready)
            begin
                if (s_gap > 0 && !steady)
                begin
                    s_tvalid <= 1'b0;
                    s_gap    <= s_gap - 1;
                end
                else if (cluster_cmds.size() > 0)
                begin
                    offered = cluster_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, offered.weight_value, offered.dim_index,
                                 offered.cluster_index, offered.feature_bits};
                    s_tuser  <= offered.mode;
                    s_gap    <= steady ? 0 : draw_gap();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    s_gap    <= 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus the long hold-off window.
    // Each taken result is checked field by field against the oldest
    // prediction.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        clc_pkg::result_t got;
        clc_pkg::result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            m_gap    <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = clc_pkg::result_t'(m_tdata[53:0]);
                if (winner_reports_due.size() == 0)
                begin
                    $error("result item with no prediction pending: %h", m_tdata);
                    n_errors++;
                end
                else
                begin
                    want = winner_reports_due.pop_front();
                    check_field("winner", want.winner, got.winner);
                    check_field("winner_distance", want.winner_distance, got.winner_distance);
                    check_field("weights_updated", want.weights_updated, got.weights_updated);
                    check_field("learning_done", want.learning_done, got.learning_done);
                    check_field("epochs_done", want.epochs_done, got.epochs_done);
                end
            end
            if (long_stall)
            begin
                m_tready <= 1'b0;
            end
            else if (m_gap > 0 && !steady)
            begin
                m_tready <= 1'b0;
                m_gap    <= m_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    m_gap <= draw_gap();
            end
        end
    end

    // Long receiver hold-off while the sender still has items to offer,
    // so the core fills up and drops s_tready.
    initial
    begin
        wait (n_accepted >= 80);
        @(posedge clk);
        long_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_stall <= 1'b0;
    end

    // Run limit: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------

    // Wait until the driver has nothing left and every result has come,
    // then let the core's latency pass so it is truly idle.
    task automatic wait_drained();
        while (cluster_cmds.size() != 0 || s_tvalid || winner_reports_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            clc_pkg::REG_ALPHA_INIT:   r_alpha = val;
            clc_pkg::REG_DECAY_RATE:   r_decay = val;
            clc_pkg::REG_MIN_ALPHA:    r_floor = val;
            clc_pkg::REG_EPOCH_LENGTH: r_len   = val[7:0];
            default:          ;
        endcase
    endtask

    // Drain, then program all four registers.
    task automatic program_regs(int alpha, int decay, int floor_rate, int len);
        wait_drained();
        write_reg(clc_pkg::REG_ALPHA_INIT, alpha[15:0]);
        write_reg(clc_pkg::REG_DECAY_RATE, decay[15:0]);
        write_reg(clc_pkg::REG_MIN_ALPHA, floor_rate[15:0]);
        write_reg(clc_pkg::REG_EPOCH_LENGTH, {8'd0, len[7:0]});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_RESTART, 0, 0, 0, 0));
        repeat (n)
            cluster_cmds.push_back(random_cmd());
    endtask

    initial
    begin
        // Power-up state of the predictor.
        for (int c = 0; c < CLUSTERS; c++)
            for (int j = 0; j < DIM; j++)
                weights[c][j] = '0;
        weights[0][0] = 16'd6553;
        weights[0][1] = 16'd19660;
        weights[0][2] = 16'd16384;
        weights[0][3] = 16'd29491;
        weights[1][0] = 16'd26214;
        weights[1][1] = 16'd13107;
        weights[1][2] = 16'd22937;
        weights[1][3] = 16'd9830;
        r_alpha  = clc_pkg::ALPHA_INIT_RST;
        r_decay  = clc_pkg::DECAY_RATE_RST;
        r_floor  = clc_pkg::MIN_ALPHA_RST;
        r_len    = clc_pkg::EPOCH_LENGTH_RST;
        lrate    = r_alpha;
        ep_items = '0;
        ep_count = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Tiny rate: a step toward an all-ones vector truncates to nothing,
        // and a zero epoch length ends an epoch on every training item.
        program_regs(1, 62915, 0, 0);
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_RESTART, 0, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 15, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 0, 0, 0, 0));

        // Floor at the top: training only classifies and is not counted.
        program_regs(32768, 62915, 65535, 4);
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_RESTART, 0, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 5, 0, 0, 0));

        // Reset settings: extremes of the vector, one full epoch and a partial one.
        program_regs(32768, 62915, 655, 4);
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_RESTART, 0, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_CLASSIFY, 0, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_CLASSIFY, 15, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 5, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 10, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 0, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 15, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 3, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 12, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 6, 0, 0, 0));

        // Epoch length lowered below the running count: next training item
        // still closes the epoch. Then fill both clusters with the largest
        // weight for a tie and a saturated distance, and try loads that miss.
        program_regs(32768, 62915, 655, 1);
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 9, 0, 0, 0));
        for (int c = 0; c < CLUSTERS; c++)
            for (int j = 0; j < DIM; j++)
                cluster_cmds.push_back(make_cmd(clc_pkg::MODE_LOAD, 0, c, j, 65535));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_LOAD, 0, 7, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_LOAD, 0, 0, 15, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_LOAD, 0, 1, DIM, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_CLASSIFY, 0, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_TRAIN, 0, 0, 0, 0));
        cluster_cmds.push_back(make_cmd(clc_pkg::MODE_RESTART, 0, 0, 0, 0));

        // Random phases over a spread of settings, extremes included.
        program_regs(32768, 62915, 655, 4);
        random_phase(150);
        program_regs(65535, 65535, 0, 255);
        random_phase(90);
        program_regs(65535, 0, 0, 1);
        random_phase(80);
        program_regs(1, 32768, 0, 0);
        random_phase(70);
        program_regs(20000, 50000, 19999, 2);
        random_phase(90);
        program_regs(0, 0, 65535, 3);
        random_phase(60);

        // Back to reset settings with no idling on either side.
        program_regs(32768, 62915, 655, 4);
        steady <= 1'b1;
        random_phase(80);
        wait_drained();
        steady <= 1'b0;

        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
